[sv/weighted_keyword_spotter_blend_top_macros.svh]
// Assertion macros for the checker of the keyword spotter.
`ifndef WEIGHTED_KEYWORD_SPOTTER_BLEND_TOP_MACROS_SVH
`define WEIGHTED_KEYWORD_SPOTTER_BLEND_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WKSB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property on every clock edge, reset cycles included.
`define WKSB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

[sv/wksb_pkg.sv]
// Package with keyword table, blend constants and shared types of the keyword spotter.
`timescale 1ns / 1ps
package wksb_pkg;

  localparam int WINDOW_BYTES = 9;
  localparam int NUM_KEYWORDS = 12;
  localparam int HIST_DEPTH   = WINDOW_BYTES - 1;
  localparam int FILL_W       = $clog2(HIST_DEPTH + 1);
  localparam int KW_TOTAL     = 12;
  localparam int KW_MAX_LEN   = 9;
  localparam int KW_IDX_W     = 4;

  localparam logic signed [17:0] Q_ONE     = 18'sd16384;
  localparam logic signed [17:0] Q_NEG_ONE = -18'sd16384;
  localparam logic signed [31:0] MIX_PRIOR = 32'sd10650;
  localparam logic signed [31:0] MIX_KEY   = 32'sd5734;
  localparam logic signed [31:0] MIX_ROUND = 32'sd8192;

  // last character of each keyword in the low byte
  localparam logic [8*KW_MAX_LEN-1:0] KW_STR [KW_TOTAL] = '{
    "grief", "betrayed", "abandoned", "regret", "longing", "hope",
    "relief", "calm", "rage", "terror", "joy", "ecstatic"
  };

  localparam int KW_LEN [KW_TOTAL] = '{5, 8, 9, 6, 7, 4, 6, 4, 4, 6, 3, 8};

  localparam logic signed [15:0] KW_VAL [KW_TOTAL] = '{
    -16'sd15073, -16'sd14418, -16'sd14746, -16'sd12124, -16'sd7537, 16'sd9830,
    16'sd8520, 16'sd5734, -16'sd14746, -16'sd16056, 16'sd15073, 16'sd16056
  };

  localparam logic [14:0] KW_ARO [KW_TOTAL] = '{
    15'd8520, 15'd10813, 15'd9830, 15'd7700, 15'd7209, 15'd9503,
    15'd5571, 15'd3277, 15'd15565, 15'd16056, 15'd13435, 15'd15565
  };

  // keyword indexes by descending weight, earlier entry first on equal weight
  localparam int KW_RANK [KW_TOTAL] = '{0, 9, 11, 1, 8, 10, 2, 3, 5, 6, 4, 7};

  typedef struct packed {
    logic                       found;
    logic [KW_IDX_W-1:0]        index;
    logic signed [15:0]         prior_valence;
    logic [14:0]                prior_arousal;
    logic                       replaceable;
  } wksb_pick_t;

endpackage

[sv/wksb_scan.sv]
// Input register, byte history, keyword match and best-keyword pick.
`timescale 1ns / 1ps
module wksb_scan
  import wksb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               byte_present,
  input  logic               last_byte,
  input  logic signed [15:0] prior_valence,
  input  logic [14:0]        prior_arousal,
  input  logic               name_replaceable,
  output logic               pick_valid,
  input  logic               pick_ready,
  output wksb_pick_t         pick
);

  logic                    v1_r;
  logic [7:0]              byte_r;
  logic                    present_r;
  logic                    last_r;
  logic signed [15:0]      pv_r;
  logic [14:0]             pa_r;
  logic                    repl_r;

  logic [8*HIST_DEPTH-1:0] hist_r, hist_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [KW_TOTAL-1:0]     mask_r, mask_nxt;
  logic                    pick_valid_r;
  wksb_pick_t              pick_r, pick_nxt;

  logic [7:0]              cur;
  logic [8*WINDOW_BYTES-1:0] win;
  logic [KW_TOTAL-1:0]     hits;
  logic [KW_TOTAL-1:0]     mask_all;
  logic                    s1_fire;
  logic                    in_fire;

  assign s1_fire  = v1_r && (!last_r || !pick_valid_r || pick_ready);
  assign in_ready = !v1_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cur = byte_r;
    if (byte_r inside {[8'h41:8'h5A]}) begin
      cur = byte_r + 8'd32;
    end
  end

  assign win = {hist_r, cur};

  always_comb begin
    logic ok;
    hits = '0;
    for (int k = 0; k < KW_TOTAL; k++) begin
      ok = present_r && (k < NUM_KEYWORDS) && (KW_LEN[k] > 0) &&
           (KW_LEN[k] - 1 <= int'(fill_r)) && (KW_LEN[k] - 1 <= HIST_DEPTH);
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < KW_LEN[k] && win[8*j +: 8] != KW_STR[k][8*j +: 8]) begin
          ok = 1'b0;
        end
      end
      hits[k] = ok;
    end
  end

  assign mask_all = mask_r | hits;

  always_comb begin
    pick_nxt.found         = |mask_all;
    pick_nxt.index         = '0;
    pick_nxt.prior_valence = pv_r;
    pick_nxt.prior_arousal = pa_r;
    pick_nxt.replaceable   = repl_r;
    for (int r = KW_TOTAL - 1; r >= 0; r--) begin
      if (mask_all[KW_RANK[r]]) begin
        pick_nxt.index = KW_IDX_W'(KW_RANK[r]);
      end
    end
  end

  always_comb begin
    hist_nxt = hist_r;
    fill_nxt = fill_r;
    mask_nxt = mask_all;
    if (present_r) begin
      hist_nxt = win[8*HIST_DEPTH-1:0];
      if (int'(fill_r) < HIST_DEPTH) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
    if (last_r) begin
      hist_nxt = '0;
      fill_nxt = '0;
      mask_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      hist_r       <= '0;
      fill_r       <= '0;
      mask_r       <= '0;
      pick_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        v1_r <= 1'b1;
      end else if (s1_fire) begin
        v1_r <= 1'b0;
      end
      if (s1_fire) begin
        hist_r <= hist_nxt;
        fill_r <= fill_nxt;
        mask_r <= mask_nxt;
      end
      if (s1_fire && last_r) begin
        pick_valid_r <= 1'b1;
      end else if (pick_ready) begin
        pick_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r    <= text_byte;
      present_r <= byte_present;
      last_r    <= last_byte;
      pv_r      <= prior_valence;
      pa_r      <= prior_arousal;
      repl_r    <= name_replaceable;
    end
    if (s1_fire && last_r) begin
      pick_r <= pick_nxt;
    end
  end

  assign pick_valid = pick_valid_r;
  assign pick       = pick_r;

endmodule

[sv/wksb_blend.sv]
// Valence and arousal blend, clamp and result register.
`timescale 1ns / 1ps
module wksb_blend
  import wksb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pick_valid,
  output logic               pick_ready,
  input  wksb_pick_t         pick,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               keyword_found,
  output logic [KW_IDX_W-1:0] keyword_index,
  output logic signed [15:0] new_valence,
  output logic [14:0]        new_arousal,
  output logic               replace_name
);

  logic                      valid_r;
  logic                      found_r;
  logic [KW_IDX_W-1:0]       index_r;
  logic signed [15:0]        val_r, val_nxt;
  logic [14:0]               aro_r, aro_nxt;
  logic                      repl_r;

  logic signed [15:0]        kw_val;
  logic [14:0]               kw_aro;
  logic signed [31:0]        val_sum;
  logic signed [31:0]        aro_sum;
  logic signed [17:0]        val_q;
  logic signed [17:0]        aro_q;

  assign pick_ready = !valid_r || res_ready;

  always_comb begin
    kw_val = KW_VAL[0];
    kw_aro = KW_ARO[0];
    for (int k = 0; k < KW_TOTAL; k++) begin
      if (pick.index == KW_IDX_W'(k)) begin
        kw_val = KW_VAL[k];
        kw_aro = KW_ARO[k];
      end
    end
  end

  assign val_sum = 32'(pick.prior_valence) * MIX_PRIOR + 32'(kw_val) * MIX_KEY + MIX_ROUND;
  assign aro_sum = $signed({17'b0, pick.prior_arousal}) * MIX_PRIOR
                 + $signed({17'b0, kw_aro}) * MIX_KEY + MIX_ROUND;
  assign val_q   = val_sum[31:14];
  assign aro_q   = aro_sum[31:14];

  always_comb begin
    if (!pick.found) begin
      val_nxt = pick.prior_valence;
      aro_nxt = pick.prior_arousal;
    end else begin
      if (val_q < Q_NEG_ONE) begin
        val_nxt = Q_NEG_ONE[15:0];
      end else if (val_q > Q_ONE) begin
        val_nxt = Q_ONE[15:0];
      end else begin
        val_nxt = val_q[15:0];
      end
      if (aro_q < 18'sd0) begin
        aro_nxt = '0;
      end else if (aro_q > Q_ONE) begin
        aro_nxt = Q_ONE[14:0];
      end else begin
        aro_nxt = aro_q[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pick_ready) begin
      valid_r <= pick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_valid && pick_ready) begin
      found_r <= pick.found;
      index_r <= pick.found ? pick.index : '0;
      val_r   <= val_nxt;
      aro_r   <= aro_nxt;
      repl_r  <= pick.found && pick.replaceable;
    end
  end

  assign res_valid     = valid_r;
  assign keyword_found = found_r;
  assign keyword_index = index_r;
  assign new_valence   = val_r;
  assign new_arousal   = aro_r;
  assign replace_name  = repl_r;

endmodule

[sv/weighted_keyword_spotter_blend_top.sv]
// Top level of the weighted keyword spotter with valence and arousal blend.
//
//  channel | dir | tdata (low bit up)                              | tuser        | tlast
//  in_     | in  | text_byte, prior_valence, prior_arousal, name_r. | byte_present | last_byte
//  out_    | out | keyword_index, new_valence, new_arousal, repl.   | keyword_found| -
//
// One item per cycle unless a stall on out_tready holds back a text end; a result passes the
// input register, the match and pick register and the blend register before it leaves.
// Reset clears all valid flags, the byte history, the fill count and the keyword mask.
// A stall on out_tready backs up stage by stage; items that end no text pass the
// match stage without waiting on the output side.
`timescale 1ns / 1ps
module weighted_keyword_spotter_blend_top
  import wksb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // text_byte, prior_valence, prior_arousal, name_replaceable
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // keyword_index, new_valence, new_arousal, replace_name, zero fill
  output logic        out_tuser   // keyword_found
);

  logic                pick_valid;
  logic                pick_ready;
  wksb_pick_t          pick;
  logic                keyword_found;
  logic [KW_IDX_W-1:0] keyword_index;
  logic signed [15:0]  new_valence;
  logic [14:0]         new_arousal;
  logic                replace_name;

  wksb_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .text_byte        (in_tdata[7:0]),
    .byte_present     (in_tuser),
    .last_byte        (in_tlast),
    .prior_valence    (in_tdata[23:8]),
    .prior_arousal    (in_tdata[38:24]),
    .name_replaceable (in_tdata[39]),
    .pick_valid       (pick_valid),
    .pick_ready       (pick_ready),
    .pick             (pick)
  );

  wksb_blend u_blend (
    .clk           (clk),
    .rst_n         (rst_n),
    .pick_valid    (pick_valid),
    .pick_ready    (pick_ready),
    .pick          (pick),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .keyword_found (keyword_found),
    .keyword_index (keyword_index),
    .new_valence   (new_valence),
    .new_arousal   (new_arousal),
    .replace_name  (replace_name)
  );

  assign out_tdata = {4'b0, replace_name, new_arousal, new_valence, keyword_index};
  assign out_tuser = keyword_found;

endmodule

[sv/wksb_checker.sv]
// Port-level checker for the keyword spotter, bound to the top level.
`timescale 1ns / 1ps
`include "weighted_keyword_spotter_blend_top_macros.svh"
module wksb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  logic [3:0]         res_index;
  logic signed [15:0] res_valence;
  logic [14:0]        res_arousal;
  logic               res_in_range;

  assign res_index    = out_tdata[3:0];
  assign res_valence  = out_tdata[19:4];
  assign res_arousal  = out_tdata[34:20];
  assign res_in_range = (res_valence >= -16'sd16384) && (res_valence <= 16'sd16384) &&
                        (res_arousal <= 15'd16384) && (res_index <= 4'd11);

  `WKSB_ASSERT(a_nomatch_zero, out_tvalid && !out_tuser |-> res_index == 4'd0 && !out_tdata[35])
  `WKSB_ASSERT(a_match_range, out_tvalid && out_tuser |-> res_in_range)
  `WKSB_ASSERT(a_result_needs_end, out_tvalid && !$past(out_tvalid) |->
    $past(in_tlast, 3) || $past(in_tvalid, 2) || $past(in_tvalid, 3) ||
    $past(in_tvalid, 4) || $past(out_tvalid, 2) || !$past(rst_n, 3))
  `WKSB_ASSERT(a_result_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `WKSB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid)

endmodule

bind weighted_keyword_spotter_blend_top wksb_checker u_wksb_checker (.*);

[sim/weighted_keyword_spotter_blend_top_test.sv]
// Self-checking testbench for the keyword spotter: random texts, own predictor, random gaps.
`timescale 1ns / 1ps
module weighted_keyword_spotter_blend_top_test;

  localparam int RECENT_DEPTH = wksb_pkg::WINDOW_BYTES - 1;
  localparam int KW_COUNT     = 12;
  localparam int TEXT_ITEMS   = 1450;

  typedef struct {
    logic [7:0]  text_byte;
    logic        present;
    logic        last;
    logic [15:0] valence;
    logic [14:0] arousal;
    logic        replaceable;
  } text_item_t;

  typedef struct {
    logic        found;
    logic [3:0]  index;
    logic [15:0] valence;
    logic [14:0] arousal;
    logic        replace;
  } blend_result_t;

  string kw_text [KW_COUNT] = '{"grief", "betrayed", "abandoned", "regret", "longing", "hope",
                                "relief", "calm", "rage", "terror", "joy", "ecstatic"};
  int kw_weight [KW_COUNT] = '{100, 98, 95, 90, 78, 86, 82, 72, 97, 99, 96, 99};
  int kw_val [KW_COUNT] = '{-15073, -14418, -14746, -12124, -7537, 9830,
                            8520, 5734, -14746, -16056, 15073, 16056};
  int kw_aro [KW_COUNT] = '{8520, 10813, 9830, 7700, 7209, 9503,
                            5571, 3277, 15565, 16056, 13435, 15565};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  text_item_t    pending_items [$];
  blend_result_t blend_expected [$];
  text_item_t    drive_item;
  logic [7:0]    recent_bytes [RECENT_DEPTH];
  int            recent_fill;
  logic [11:0]   seen_mask;
  int            send_gap;
  int            stall_left;
  int            cycle_count;
  int            mismatch_count;

  weighted_keyword_spotter_blend_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int pick_gap();
    int r;
    if ((cycle_count / 600) % 4 == 3)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint blend_q14(longint prior, longint key, longint lo, longint hi);
    longint s;
    s = (10650 * prior + 5734 * key + 8192) >>> 14;
    return s < lo ? lo : (s > hi ? hi : s);
  endfunction

  task automatic predict_blend(text_item_t it);
    logic [7:0]    c;
    int            len;
    bit            hit;
    bit            have;
    int            best;
    blend_result_t r;
    if (it.present) begin
      c = it.text_byte;
      if (c >= "A" && c <= "Z")
        c = c + 8'd32;
      for (int k = 0; k < KW_COUNT; k++) begin
        len = kw_text[k].len();
        hit = (len - 1 <= recent_fill) && (len - 1 <= RECENT_DEPTH) && (kw_text[k][len - 1] == c);
        for (int j = 1; j < len; j++)
          if (hit && kw_text[k][len - 1 - j] != recent_bytes[j - 1])
            hit = 0;
        if (hit)
          seen_mask[k] = 1'b1;
      end
      for (int i = RECENT_DEPTH - 1; i > 0; i--)
        recent_bytes[i] = recent_bytes[i - 1];
      recent_bytes[0] = c;
      if (recent_fill < RECENT_DEPTH)
        recent_fill++;
    end
    if (!it.last)
      return;
    have = 0;
    best = 0;
    for (int k = 0; k < KW_COUNT; k++)
      if (seen_mask[k] && (!have || kw_weight[k] > kw_weight[best])) begin
        best = k;
        have = 1;
      end
    if (!have) begin
      r = '{1'b0, 4'd0, it.valence, it.arousal, 1'b0};
    end else begin
      r.found   = 1'b1;
      r.index   = 4'(best);
      r.valence = 16'(blend_q14(longint'($signed(it.valence)), kw_val[best], -16384, 16384));
      r.arousal = 15'(blend_q14(longint'(it.arousal), kw_aro[best], 0, 16384));
      r.replace = it.replaceable;
    end
    blend_expected.push_back(r);
    foreach (recent_bytes[i])
      recent_bytes[i] = 8'd0;
    recent_fill = 0;
    seen_mask = '0;
  endtask

  task automatic push_item(logic [7:0] b, logic present, logic last,
                           logic [15:0] pv, logic [14:0] pa, logic repl);
    text_item_t it;
    it = '{b, present, last, pv, pa, repl};
    pending_items.push_back(it);
  endtask

  task automatic push_word(string w, logic last, logic [15:0] pv, logic [14:0] pa, logic repl);
    for (int i = 0; i < w.len(); i++)
      push_item(w[i], 1'b1, last && i == w.len() - 1, pv, pa, repl);
  endtask

  task automatic pick_priors(output logic [15:0] pv, output logic [14:0] pa);
    logic [15:0] pv_edges [5] = '{16'hC000, 16'h4000, 16'h7FFF, 16'h8000, 16'h0000};
    logic [14:0] pa_edges [3] = '{15'd0, 15'd16384, 15'h7FFF};
    case ($urandom_range(0, 4))
      0: begin
        pv = pv_edges[$urandom_range(0, 4)];
        pa = pa_edges[$urandom_range(0, 2)];
      end
      1, 2: begin
        pv = 16'($urandom_range(0, 32768) - 16384);
        pa = 15'($urandom_range(0, 16384));
      end
      default: begin
        pv = 16'($urandom);
        pa = 15'($urandom);
      end
    endcase
  endtask

  function automatic text_item_t noise_item(logic [7:0] b, logic present);
    text_item_t it;
    it = '{b, present, 1'b0, 16'($urandom), 15'($urandom), 1'($urandom)};
    return it;
  endfunction

  task automatic add_random_text();
    text_item_t  parts [$];
    logic [15:0] pv;
    logic [14:0] pa;
    string       w;
    int          n;
    int          cut;
    logic [7:0]  c;
    if ($urandom_range(0, 99) >= 8) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            w = kw_text[$urandom_range(0, KW_COUNT - 1)];
            n = w.len();
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n; i++) begin
              c = w[i];
              if (i == cut)
                c = ($urandom_range(0, 1) == 0) ? "x" : 8'($urandom);
              if ($urandom_range(0, 1) == 0 && c >= "a" && c <= "z")
                c = c - 8'd32;
              parts.push_back(noise_item(c, 1'b1));
              if ($urandom_range(0, 19) == 0)
                parts.push_back(noise_item(8'($urandom), 1'b0));
            end
          end
          4, 5, 6:
            repeat ($urandom_range(1, 5))
              parts.push_back(noise_item(8'("a" + $urandom_range(0, 25) -
                                         ($urandom_range(0, 1) ? 32 : 0)), 1'b1));
          7, 8:
            repeat ($urandom_range(1, 3))
              parts.push_back(noise_item(8'($urandom), 1'b1));
          default:
            repeat ($urandom_range(1, 2))
              parts.push_back(noise_item(8'($urandom), 1'b0));
        endcase
      end
    end
    if (parts.size() == 0 || $urandom_range(0, 4) == 0)
      parts.push_back(noise_item(8'($urandom), 1'($urandom_range(0, 3) == 0)));
    pick_priors(pv, pa);
    parts[$].last = 1'b1;
    parts[$].valence = pv;
    parts[$].arousal = pa;
    foreach (parts[i])
      pending_items.push_back(parts[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
      cycle_count <= 0;
      recent_fill = 0;
      seen_mask = '0;
      foreach (recent_bytes[i])
        recent_bytes[i] = 8'd0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (in_tvalid && in_tready)
        predict_blend('{in_tdata[7:0], in_tuser, in_tlast, in_tdata[23:8], in_tdata[38:24],
                        in_tdata[39]});
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drive_item = pending_items.pop_front();
          in_tdata <= {drive_item.replaceable, drive_item.arousal, drive_item.valence,
                       drive_item.text_byte};
          in_tuser <= drive_item.present;
          in_tlast <= drive_item.last;
          in_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    blend_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
      if (out_tvalid && out_tready) begin
        if (blend_expected.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata[3:0], -1);
        end else begin
          want = blend_expected.pop_front();
          if (out_tuser !== want.found)
            report_mismatch("keyword_found", out_tuser, want.found);
          if (out_tdata[3:0] !== want.index)
            report_mismatch("keyword_index", out_tdata[3:0], want.index);
          if (out_tdata[19:4] !== want.valence)
            report_mismatch("new_valence", $signed(out_tdata[19:4]), $signed(want.valence));
          if (out_tdata[34:20] !== want.arousal)
            report_mismatch("new_arousal", out_tdata[34:20], want.arousal);
          if (out_tdata[35] !== want.replace)
            report_mismatch("replace_name", out_tdata[35], want.replace);
          if (out_tdata[39:36] !== 4'd0)
            report_mismatch("zero fill", out_tdata[39:36], 0);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    // empty text with priors far outside the legal range
    push_item(8'hFF, 1'b0, 1'b1, 16'h8000, 15'h7FFF, 1'b1);
    // longest keyword, an absent byte inside it, mixed case
    push_word("aBAND", 1'b0, 16'h0000, 15'd0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0, 16'hFFFF, 15'h7FFF, 1'b1);
    push_word("ONED", 1'b1, 16'hC000, 15'd0, 1'b1);
    push_word("JoY", 1'b1, 16'h4000, 15'd16384, 1'b0);
    // bytes at the edges of the fold range, no keyword, absent final item
    push_item(8'h00, 1'b1, 1'b0, 16'h0000, 15'd0, 1'b0);
    push_item(8'h40, 1'b1, 1'b0, 16'h0000, 15'd0, 1'b0);
    push_item(8'h5B, 1'b1, 1'b0, 16'h0000, 15'd0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0, 16'h0000, 15'd0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 16'h7FFF, 15'h4001, 1'b1);
    push_word("hope", 1'b0, 16'h0000, 15'd0, 1'b0);
    push_item(8'h41, 1'b0, 1'b1, 16'h7FFF, 15'h7FFF, 1'b1);
    while (pending_items.size() < TEXT_ITEMS)
      add_random_text();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do
      @(posedge clk);
    while (pending_items.size() > 0 || in_tvalid || blend_expected.size() > 0);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #1600000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
